@@ design/fdr_pkg.sv @@
// ----------------------------------------------------------------------------
// fdr_pkg: shared types and constants for the framed datagram receiver
// Result codes, frame geometry, store sizing and the structs that link the
// frame parser, the payload store and the result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package fdr_pkg;

  localparam int STORE_DEPTH     = 131072;
  localparam int MAX_FRAME_BYTES = 2048;

  // Store address, committed count and byte position widths
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 2);

  // Compare widths: position vs length+9, write address, store-full test
  localparam int CMP_W  = ((POS_W > 17) ? POS_W : 17) + 1;
  localparam int WA_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int FULL_W = ((CNT_W > 16) ? CNT_W : 16) + 1;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_SEQUENCE = 3'd2;
  localparam logic [2:0] ST_LENGTH   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // Ack frame constants
  localparam logic [7:0] ACK_FLAG = 8'h7E;
  localparam logic [7:0] ACK_FILL = 8'hFF;
  localparam int         ACK_LEN  = 9;
  localparam logic [15:0] ACK_SUM_BASE =
    16'(ACK_FLAG) + 16'(ACK_FILL) + 16'(ACK_FILL);

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [2:0]       status;
    logic [CNT_W-1:0] count;
    logic [7:0]       cmd;
    logic [7:0]       frame;
    logic             in_range;
  } result_t;

endpackage

`default_nettype wire

@@ design/fdr_store.sv @@
// ----------------------------------------------------------------------------
// fdr_store: payload byte store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_store (
  input  logic              clk,
  input  fdr_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [fdr_pkg::STORE_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    // holds between reads so a stalled read result stays put
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/fdr_frame.sv @@
// ----------------------------------------------------------------------------
// fdr_frame: datagram byte parser and frame verdict
// Tracks header fields, checksum and position; issues store writes and
// reads; decides accept/reject at end of datagram.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_frame (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               action,
  input  logic [7:0]         frame_byte,
  input  logic               end_of_datagram,
  input  logic [16:0]        read_address,
  output fdr_pkg::mem_req_t  mem_req,
  output fdr_pkg::result_t   result
);

  localparam int PW = fdr_pkg::POS_W;
  localparam int CW = fdr_pkg::CMP_W;
  localparam int NW = fdr_pkg::CNT_W;
  localparam int WW = fdr_pkg::WA_W;
  localparam int FW = fdr_pkg::FULL_W;
  localparam int AW = fdr_pkg::ADDR_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    frm_r, frm_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [15:0]   sum_r, sum_nxt;
  logic [15:0]   rsum_r, rsum_nxt;
  logic [7:0]    seq_r;
  logic [NW-1:0] cnt_r;

  logic          is_byte, is_end, in_win;
  logic [CW-1:0] p_ext, len_ext;
  logic [WW-1:0] wa;
  logic [NW:0]   ra_ext;
  logic [FW-1:0] full_sum;
  logic [2:0]    status;
  logic          ok;

  assign is_byte = accept && (action == fdr_pkg::ACT_BYTE);
  assign is_end  = is_byte && end_of_datagram;
  assign p_ext   = CW'(pos_r);
  assign len_ext = CW'(len_r);
  assign in_win  = p_ext < CW'(fdr_pkg::MAX_FRAME_BYTES);
  assign wa      = WW'(cnt_r) + WW'(pos_r) - WW'(7);

  always_comb begin
    cmd_nxt  = cmd_r;
    frm_nxt  = frm_r;
    len_nxt  = len_r;
    sum_nxt  = sum_r;
    rsum_nxt = rsum_r;
    if (in_win) begin
      if (p_ext == CW'(3)) cmd_nxt = frame_byte;
      if (p_ext == CW'(4)) frm_nxt = frame_byte;
      if (p_ext == CW'(5)) len_nxt = {frame_byte, 8'h00};
      if (p_ext == CW'(6)) len_nxt = len_r | {8'h00, frame_byte};
      if ((p_ext <= CW'(6)) || (p_ext <= len_ext + CW'(6))) begin
        sum_nxt = sum_r + {8'h00, frame_byte};
      end
      if ((p_ext >= CW'(7)) && (p_ext == len_ext + CW'(7))) begin
        rsum_nxt = {frame_byte, 8'h00};
      end
      if ((p_ext >= CW'(7)) && (p_ext == len_ext + CW'(8))) begin
        rsum_nxt = rsum_r | {8'h00, frame_byte};
      end
    end
    // count saturates one past the frame limit
    pos_nxt = (p_ext <= CW'(fdr_pkg::MAX_FRAME_BYTES)) ? pos_r + PW'(1) : pos_r;
  end

  // Payload write, only while inside the store
  always_comb begin
    mem_req.wr_en   = is_byte && in_win && (p_ext >= CW'(7)) &&
                      (p_ext <= len_ext + CW'(6)) &&
                      (wa < WW'(fdr_pkg::STORE_DEPTH));
    mem_req.wr_addr = wa[AW-1:0];
    mem_req.wr_data = frame_byte;
    ra_ext          = (NW+1)'(read_address);
    mem_req.rd_en   = accept && (action == fdr_pkg::ACT_READ);
    mem_req.rd_addr = ra_ext[AW-1:0];
  end

  // Verdict, in priority order
  assign full_sum = FW'(cnt_r) + FW'(len_nxt);
  always_comb begin
    if ((CW'(pos_nxt) > CW'(fdr_pkg::MAX_FRAME_BYTES)) ||
        (CW'(pos_nxt) != CW'(len_nxt) + CW'(9))) begin
      status = fdr_pkg::ST_LENGTH;
    end else if (sum_nxt != rsum_nxt) begin
      status = fdr_pkg::ST_CHECKSUM;
    end else if ((frm_nxt != seq_r) && (frm_nxt != seq_r + 8'd1)) begin
      status = fdr_pkg::ST_SEQUENCE;
    end else if (full_sum > FW'(fdr_pkg::STORE_DEPTH)) begin
      status = fdr_pkg::ST_FULL;
    end else begin
      status = fdr_pkg::ST_OK;
    end
  end
  assign ok = (status == fdr_pkg::ST_OK);

  always_comb begin
    result.cmd      = cmd_nxt;
    result.frame    = frm_nxt;
    result.in_range = ra_ext < (NW+1)'(fdr_pkg::STORE_DEPTH);
    if (action == fdr_pkg::ACT_READ) begin
      result.kind   = fdr_pkg::KIND_READ;
      result.status = fdr_pkg::ST_OK;
      result.count  = cnt_r;
    end else if (ok) begin
      result.kind   = fdr_pkg::KIND_ACK;
      result.status = fdr_pkg::ST_OK;
      result.count  = cnt_r + NW'(len_nxt);
    end else begin
      result.kind   = fdr_pkg::KIND_REJECT;
      result.status = status;
      result.count  = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      cmd_r  <= '0;
      frm_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      rsum_r <= '0;
      seq_r  <= '0;
      cnt_r  <= '0;
    end else if (is_end) begin
      pos_r  <= '0;
      cmd_r  <= '0;
      frm_r  <= '0;
      len_r  <= '0;
      sum_r  <= '0;
      rsum_r <= '0;
      if (ok) begin
        cnt_r <= cnt_r + NW'(len_nxt);
        seq_r <= seq_r + 8'd1;
      end
    end else if (is_byte) begin
      pos_r  <= pos_nxt;
      cmd_r  <= cmd_nxt;
      frm_r  <= frm_nxt;
      len_r  <= len_nxt;
      sum_r  <= sum_nxt;
      rsum_r <= rsum_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/fdr_out.sv @@
// ----------------------------------------------------------------------------
// fdr_out: result register and ack sequencer
// Holds one pending result; an ack is played out as nine words.
// ----------------------------------------------------------------------------
`default_nettype none

module fdr_out (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  fdr_pkg::result_t res_in,
  input  logic [7:0]       rd_data,
  output logic             load_ok,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic [2:0]       out_status,
  output logic [17:0]      out_committed_count
);

  logic             valid_r;
  fdr_pkg::result_t res_r;
  logic [3:0]       idx_r;
  logic [15:0]      ack_sum;
  logic             is_ack;
  logic             take;

  assign is_ack  = (res_r.kind == fdr_pkg::KIND_ACK);
  assign ack_sum = fdr_pkg::ACK_SUM_BASE + 16'(res_r.cmd) + 16'(res_r.frame);

  assign out_valid           = valid_r;
  assign out_kind            = res_r.kind;
  assign out_status          = res_r.status;
  assign out_committed_count = 18'(res_r.count);
  assign out_last_of_run     = is_ack ? (idx_r == 4'(fdr_pkg::ACK_LEN - 1)) : 1'b1;

  always_comb begin
    if (is_ack) begin
      case (idx_r)
        4'd0:    out_byte = fdr_pkg::ACK_FLAG;
        4'd1:    out_byte = fdr_pkg::ACK_FILL;
        4'd2:    out_byte = fdr_pkg::ACK_FILL;
        4'd3:    out_byte = res_r.cmd;
        4'd4:    out_byte = res_r.frame;
        4'd7:    out_byte = ack_sum[15:8];
        4'd8:    out_byte = ack_sum[7:0];
        default: out_byte = 8'h00;
      endcase
    end else if (res_r.kind == fdr_pkg::KIND_READ) begin
      out_byte = res_r.in_range ? rd_data : 8'h00;
    end else begin
      out_byte = 8'h00;
    end
  end

  assign take    = valid_r && !out_stall;
  assign load_ok = !valid_r || (take && out_last_of_run);

  // a load only comes with an empty register or with its final word leaving
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      idx_r <= out_last_of_run ? 4'd0 : idx_r + 4'd1;
      if (out_last_of_run) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res_in;
  end

endmodule

`default_nettype wire

@@ design/framed_datagram_receiver_with_ack.sv @@
// ----------------------------------------------------------------------------
// framed_datagram_receiver_with_ack: datagram receiver with ack generation
// Input channel (in_*): one word per accepted handshake, either a datagram
// byte (in_action = 0) or a payload-store read (in_action = 1).
// Output channel (out_*): ack bytes, reject notices and read data.
// A read or a verdict shows on out_* in the cycle after the word that
// causes it is accepted (read data comes off the store's registered port).
// Throughput: one input word per cycle. Datagram bytes that produce no result
// are always taken, one per cycle. A word that produces a result (a read or
// a datagram's last byte) is taken once the result register is free or its
// final word leaves in the same cycle; an accepted frame holds that register
// for the nine ack words, so at most one result word leaves per cycle.
// Payload bytes go into the store as they arrive; each byte does at most one
// store write, each read one store read.
// Reset: frame state, expected sequence and committed count go to zero. The
// store is not cleared; reading a never-written entry gives undefined data.
// out_stall: the pending result holds; only result-producing input words
// back up on in_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_datagram_receiver_with_ack (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_end_of_datagram,
  input  logic [16:0] in_read_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic [2:0]  out_status,
  output logic [17:0] out_committed_count
);

  fdr_pkg::mem_req_t mem_req;
  fdr_pkg::result_t  result;
  logic [7:0]        rd_data;
  logic              load_ok;
  logic              makes_result;
  logic              accept;

  // reads and end-of-datagram bytes need the result register
  assign makes_result = (in_action == fdr_pkg::ACT_READ) || in_end_of_datagram;
  assign in_stall     = makes_result && !load_ok;
  assign accept       = in_valid && !in_stall;

  fdr_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .action          (in_action),
    .frame_byte      (in_frame_byte),
    .end_of_datagram (in_end_of_datagram),
    .read_address    (in_read_address),
    .mem_req         (mem_req),
    .result          (result)
  );

  fdr_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  fdr_out u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (accept && makes_result),
    .res_in              (result),
    .rd_data             (rd_data),
    .load_ok             (load_ok),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_kind            (out_kind),
    .out_byte            (out_byte),
    .out_last_of_run     (out_last_of_run),
    .out_status          (out_status),
    .out_committed_count (out_committed_count)
  );

endmodule

`default_nettype wire
